[hw/rtl/ioxs_pkg.sv]
// Package for the I/O expander request sequencer.
// Holds codes, field widths and constants; no dependencies.
package ioxs_pkg;
  localparam int QueueDepthDef = 8;
  localparam logic [15:0] TimeoutResetMs = 16'd500;
  localparam logic [7:0] RegOutput = 8'hF0;
  localparam logic [7:0] RegWrite = 8'h10;
  localparam logic [7:0] RegRead = 8'h20;
  localparam logic [7:0] ReadIdle = 8'hFF;

  localparam logic [2:0] CmdAddr = 3'd0;
  localparam logic [2:0] CmdWrite = 3'd1;
  localparam logic [2:0] CmdRead = 3'd2;
  localparam logic [2:0] CmdContStart = 3'd3;
  localparam logic [2:0] CmdContStop = 3'd4;
  localparam logic [2:0] CmdBlank = 3'd5;

  localparam logic [1:0] KindReply = 2'd0;
  localparam logic [1:0] KindBusWrite = 2'd1;
  localparam logic [1:0] KindBusRead = 2'd2;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StBadInput = 3'd1;
  localparam logic [2:0] StNoResource = 3'd2;
  localparam logic [2:0] StTimeout = 3'd3;
  localparam logic [2:0] StBusError = 3'd4;
  localparam logic [2:0] StProgError = 3'd5;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhWrite = 2'd1;
  localparam logic [1:0] PhRead = 2'd2;

  localparam logic CfgAddrIdx = 1'b0;
  localparam logic CfgTimeoutIdx = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [2:0] status;
    logic [2:0] reply_cmd;
    logic       with_value;
    logic [1:0] byte_count;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       last;
  } result_t;
endpackage

[hw/rtl/ioxs_ring.sv]
// Ring storage of queued requests: one write port, one registered read port.
// Depends on ioxs_pkg.
module ioxs_ring #(
  parameter int QueueDepth = ioxs_pkg::QueueDepthDef,
  localparam int Aw = (QueueDepth > 1) ? $clog2(QueueDepth) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [Aw-1:0] wr_addr,
  input  logic [2:0]    wr_cmd,
  input  logic [7:0]    wr_value,
  input  logic [Aw-1:0] rd_addr,
  output logic [2:0]    rd_cmd,
  output logic [7:0]    rd_value
);
  import ioxs_pkg::*;
  logic [10:0] mem [QueueDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_cmd, wr_value};
    end
    {rd_cmd, rd_value} <= mem[rd_addr];
  end
endmodule

[hw/rtl/i2c_io_expander_request_sequencer_top.sv]
// Top level of the I/O expander request sequencer: sequencer FSM plus ring.
// Depends on ioxs_pkg and ioxs_ring.
//
//  channel | ports                       | handshake
//  in      | in_action .. in_now_ms      | start & !busy
//  out     | out_kind .. out_last        | out_valid strobe, one cycle
//  cfg     | cfg_index, cfg_data         | cfg_valid & cfg_ready
//
// A request passes S_IDLE and S_EMIT2; a poll runs through the read and issue
// states. A stop scan visits S_SCANRD and S_SCAN per entry walked, since every ring
// access goes through the single registered read port. At most two results per item.
// Reset is synchronous; the ring needs no clearing. Results cannot be stalled.
module i2c_io_expander_request_sequencer_top #(
  parameter int QueueDepth = ioxs_pkg::QueueDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_value,
  input  logic        in_bus_finished,
  input  logic        in_bus_error,
  input  logic [7:0]  in_read_byte,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_status,
  output logic [2:0]  out_reply_cmd,
  output logic        out_with_value,
  output logic [6:0]  out_bus_address,
  output logic [1:0]  out_byte_count,
  output logic [7:0]  out_byte0,
  output logic [7:0]  out_byte1,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import ioxs_pkg::*;
  localparam int Aw = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int Cw = $clog2(QueueDepth + 1);
  localparam logic [Cw-1:0] CntFull = Cw'(QueueDepth);
  localparam logic [Cw-1:0] CntOne = Cw'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_HEADRD, S_FINISH, S_ROTRD, S_ROTWR,
    S_ISSUERD, S_ISSUE, S_SCANRD, S_SCAN, S_EMIT2
  } state_t;

  state_t         state_r;
  logic [Aw-1:0]  head_r;
  logic [Cw-1:0]  count_r;
  logic [1:0]     phase_r;
  logic [7:0]     lastrd_r;
  logic [31:0]    issue_r;
  logic [6:0]     dev_r;
  logic [15:0]    tmo_r;
  logic           fin_r, err_r;
  logic [7:0]     rbyte_r;
  logic [31:0]    now_r;
  logic [Cw-1:0]  scan_r;
  logic           had_r;
  result_t        res_r, pend_r;
  logic [2:0]     hc_r;
  logic [7:0]     hv_r;

  logic           wr_en;
  logic [Aw-1:0]  wr_addr, rd_addr;
  logic [2:0]     wr_cmd, rd_cmd;
  logic [7:0]     wr_value, rd_value;

  function automatic logic [Aw-1:0] wrap(input logic [Aw-1:0] a, input logic [Cw-1:0] n);
    logic [Aw+Cw:0] s;
    s = (Aw+Cw+1)'(a) + (Aw+Cw+1)'(n);
    if (s >= (Aw+Cw+1)'(QueueDepth)) s = s - (Aw+Cw+1)'(QueueDepth);
    return s[Aw-1:0];
  endfunction

  ioxs_ring #(.QueueDepth(QueueDepth)) u_ring (
    .clk, .wr_en, .wr_addr, .wr_cmd, .wr_value, .rd_addr, .rd_cmd, .rd_value
  );

  logic [31:0] elapsed;
  assign elapsed = now_r - issue_r;

  // Ring port control, decided from the current state.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = wrap(head_r, count_r);
    wr_cmd = in_cmd;
    wr_value = in_value;
    rd_addr = head_r;
    case (state_r)
      S_IDLE: wr_en = start && !in_action && in_cmd <= CmdContStop && count_r != CntFull;
      S_FINISH: begin
        if (fin_r && phase_r == PhRead) begin
          wr_en = 1'b1;
          wr_addr = head_r;
          wr_cmd = rd_cmd;
          wr_value = rbyte_r;
        end
      end
      S_ROTWR: begin
        wr_en = 1'b1;
        wr_addr = wrap(head_r, count_r - CntOne);
        wr_cmd = hc_r;
        wr_value = hv_r;
      end
      S_SCANRD: rd_addr = wrap(head_r, scan_r);
      S_SCAN: begin
        rd_addr = wrap(head_r, scan_r);
        wr_addr = rd_addr;
        wr_cmd = CmdBlank;
        wr_value = rd_value;
        wr_en = rd_cmd == CmdContStart;
      end
      default: ;
    endcase
  end

  function automatic result_t reply(input logic [2:0] st, input logic [2:0] c,
                                    input logic wv, input logic [7:0] b1,
                                    input logic lst);
    result_t r;
    r = '0;
    r.valid = 1'b1;
    r.kind = KindReply;
    r.status = st;
    r.reply_cmd = c;
    r.with_value = wv;
    r.byte1 = b1;
    r.last = lst;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    state_t     state_nxt;
    result_t    res_nxt;
    result_t    r;
    logic [7:0] v;
    logic       same;
    logic [2:0] st;
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0;
      count_r <= '0;
      phase_r <= PhIdle;
      lastrd_r <= ReadIdle;
      issue_r <= '0;
      dev_r <= '0;
      tmo_r <= TimeoutResetMs;
      res_r <= '0;
      pend_r <= '0;
      had_r <= 1'b0;
    end else begin
      state_nxt = state_r;
      res_nxt = '0;
      r = '0;
      v = '0;
      same = 1'b0;
      st = StOk;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgAddrIdx: dev_r <= cfg_data[6:0];
          CfgTimeoutIdx: tmo_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            fin_r <= in_bus_finished; err_r <= in_bus_error;
            rbyte_r <= in_read_byte; now_r <= in_now_ms;
            had_r <= 1'b0;
            if (!in_action) begin
              state_nxt = S_EMIT2;
              pend_r <= '0;
              if (in_cmd > CmdContStop) begin
                res_nxt = reply(StBadInput, in_cmd, 1'b0, 8'd0, 1'b1);
              end else if (count_r == CntFull) begin
                res_nxt = reply(StNoResource, in_cmd, 1'b0, 8'd0, 1'b1);
              end else begin
                if (in_cmd == CmdContStart) lastrd_r <= ReadIdle;
                count_r <= count_r + CntOne;
              end
            end else begin
              state_nxt = S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (count_r == '0) state_nxt = S_IDLE;
          else if (phase_r != PhIdle) state_nxt = S_HEADRD;
          else state_nxt = S_ISSUERD;
        end
        S_HEADRD: state_nxt = S_FINISH; // ring read of head in flight
        S_FINISH: begin
          hc_r <= rd_cmd;
          hv_r <= (phase_r == PhRead) ? rbyte_r : rd_value;
          if (!fin_r) begin
            state_nxt = S_IDLE;
            if (elapsed >= {16'd0, tmo_r}) begin
              res_nxt = reply(StTimeout, rd_cmd, 1'b0, 8'd0, 1'b1);
              head_r <= wrap(head_r, CntOne);
              count_r <= count_r - CntOne;
              phase_r <= PhIdle;
            end
          end else if ((rd_cmd == CmdRead || rd_cmd == CmdContStart) &&
                       phase_r == PhWrite && !err_r) begin
            res_nxt = '{valid: 1'b1, kind: KindBusRead, byte_count: 2'd1,
                        last: 1'b1, default: '0};
            phase_r <= PhRead;
            state_nxt = S_IDLE;
          end else begin
            v = (phase_r == PhRead) ? rbyte_r : rd_value;
            same = (rd_cmd == CmdContStart) && lastrd_r == v;
            st = (rd_cmd <= CmdContStart) ? (err_r ? StBusError : StOk) : StProgError;
            if (rd_cmd == CmdContStart) lastrd_r <= v;
            phase_r <= PhIdle;
            state_nxt = S_ISSUERD;
            // The reply waits until it is known whether an issue result follows.
            if (rd_cmd == CmdContStart && st == StOk) begin
              if (!same) begin
                pend_r <= reply(StOk, rd_cmd, 1'b1, v, 1'b0);
                had_r <= 1'b1;
              end
              if (count_r != CntOne) begin
                head_r <= wrap(head_r, CntOne);
                if (count_r != CntFull) state_nxt = S_ROTWR;
              end
            end else begin
              pend_r <= reply(st, rd_cmd, 1'b1, v, 1'b0);
              had_r <= 1'b1;
              head_r <= wrap(head_r, CntOne);
              count_r <= count_r - CntOne;
            end
          end
        end
        S_ROTWR: state_nxt = S_ISSUERD;
        S_ISSUERD: begin
          if (count_r == '0) begin
            state_nxt = S_IDLE;
            if (had_r) begin
              res_nxt = pend_r;
              res_nxt.last = 1'b1;
            end
          end else state_nxt = S_ISSUE;
        end
        S_ISSUE: begin
          r.valid = 1'b1;
          r.last = 1'b1;
          state_nxt = S_IDLE;
          case (rd_cmd)
            CmdAddr, CmdWrite: begin
              r.kind = KindBusWrite; r.byte_count = 2'd2;
              r.byte0 = (rd_cmd == CmdAddr) ? RegOutput : RegWrite;
              r.byte1 = rd_value;
              issue_r <= now_r; phase_r <= PhWrite;
            end
            CmdRead, CmdContStart: begin
              r.kind = KindBusWrite; r.byte_count = 2'd1; r.byte0 = RegRead;
              issue_r <= now_r; phase_r <= PhWrite;
            end
            CmdContStop: begin
              r = reply(StOk, CmdContStop, 1'b0, 8'd0, 1'b1);
              scan_r <= '0;
              state_nxt = S_SCANRD;
            end
            CmdBlank: begin
              r = '0;
              head_r <= wrap(head_r, CntOne);
              count_r <= count_r - CntOne;
            end
            default: begin
              r = reply(StProgError, rd_cmd, 1'b0, 8'd0, 1'b1);
              head_r <= wrap(head_r, CntOne);
              count_r <= count_r - CntOne;
            end
          endcase
          // A waiting reply goes out first; the stop reply goes out after its scan.
          if (rd_cmd == CmdContStop) begin
            pend_r <= r;
            if (had_r) res_nxt = pend_r;
          end else if (rd_cmd == CmdBlank) begin
            if (had_r) begin
              res_nxt = pend_r;
              res_nxt.last = 1'b1;
            end
          end else if (had_r) begin
            res_nxt = pend_r;
            pend_r <= r;
            state_nxt = S_EMIT2;
          end else begin
            res_nxt = r;
          end
        end
        S_SCANRD: state_nxt = S_SCAN;
        S_SCAN: begin
          if (rd_cmd == CmdContStart || scan_r == count_r - CntOne) begin
            res_nxt = pend_r;
            head_r <= wrap(head_r, CntOne);
            count_r <= count_r - CntOne;
            state_nxt = S_IDLE;
          end else begin
            scan_r <= scan_r + CntOne;
            state_nxt = S_SCANRD;
          end
        end
        S_EMIT2: begin
          if (had_r) res_nxt = pend_r;
          state_nxt = S_IDLE;
        end
        default: state_nxt = S_IDLE;
      endcase
      state_r <= state_nxt;
      res_r <= res_nxt;
    end
  end

  assign busy = state_r != S_IDLE;
  assign cfg_ready = state_r == S_IDLE;
  assign out_valid = res_r.valid;
  assign out_kind = res_r.kind;
  assign out_status = res_r.status;
  assign out_reply_cmd = res_r.reply_cmd;
  assign out_with_value = res_r.with_value;
  assign out_bus_address = (res_r.kind == KindReply) ? 7'd0 : dev_r;
  assign out_byte_count = res_r.byte_count;
  assign out_byte0 = res_r.byte0;
  assign out_byte1 = res_r.byte1;
  assign out_last = res_r.last;

  // Results are only produced while working, and never in reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) != S_IDLE || $past(start)) else $error("stray result");
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntFull) else $error("ring count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PhIdle |-> count_r != '0) else $error("phase without entry");
endmodule
